// ===== design/key_matrix_to_boot_report_top_defines.svh =====
// Assertion macros for the key matrix to boot report block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef KEY_MATRIX_TO_BOOT_REPORT_TOP_DEFINES_SVH
`define KEY_MATRIX_TO_BOOT_REPORT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define KMBR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define KMBR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define KMBR_ASSERT_IMP(label, ante, cons)
`define KMBR_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== design/kmbr_pkg.sv =====
package kmbr_pkg;

	localparam int COLUMNS      = 2;
	localparam int ROWS         = 2;
	localparam int REPORT_SLOTS = 6;
	localparam int SLOT_COUNT   = 6;
	localparam int KEY_COUNT    = COLUMNS * ROWS;
	localparam int KEY_BITS_W   = 4;
	localparam int CODE_W       = 8;
	localparam int TABLE_W      = 64;
	localparam int TABLE_KEYS   = TABLE_W / CODE_W;
	localparam int FILL_W       = $clog2(SLOT_COUNT + 1);

	localparam logic [TABLE_W-1:0] TABLE_RESET = 64'h0000_0000_2120_1F1E;

	typedef logic [KEY_BITS_W-1:0]              key_bits_t;
	typedef logic [CODE_W-1:0]                  keycode_t;
	typedef logic [TABLE_W-1:0]                 key_table_t;
	typedef logic [SLOT_COUNT-1:0][CODE_W-1:0]  report_t;

endpackage

// ===== design/kmbr_scan_if.sv =====
interface kmbr_scan_if;
	import kmbr_pkg::*;

	logic      valid;
	logic      ready;
	key_bits_t key_bits;
	logic      host_ready;

	modport source (output valid, output key_bits, output host_ready, input ready);
	modport sink (input valid, input key_bits, input host_ready, output ready);

endinterface

// ===== design/kmbr_report_if.sv =====
interface kmbr_report_if;
	import kmbr_pkg::*;

	logic     valid;
	logic     ready;
	keycode_t slot_0;
	keycode_t slot_1;
	keycode_t slot_2;
	keycode_t slot_3;
	keycode_t slot_4;
	keycode_t slot_5;

	modport source (
		output valid, output slot_0, output slot_1, output slot_2,
		output slot_3, output slot_4, output slot_5, input ready
	);
	modport sink (
		input valid, input slot_0, input slot_1, input slot_2,
		input slot_3, input slot_4, input slot_5, output ready
	);

endinterface

// ===== design/kmbr_cfg_if.sv =====
interface kmbr_cfg_if;
	import kmbr_pkg::*;

	logic       valid;
	logic       ready;
	key_table_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ===== design/key_matrix_to_boot_report_top.sv =====
// Key matrix scan to six-key boot keyboard report converter.
// scan (sink): one matrix scan per word, key_bits with bit column*ROWS+row set
//   for a pressed key, and host_ready; a scan with host_ready low is dropped.
// report (source): slot_0..slot_5, the keycodes of the pressed keys in scan
//   order, zero where unused. A word is sent only when the report differs
//   from the last one sent, so a scan gives zero or one report word.
// cfg (sink): writes the 64-bit keycode table, one byte per key; always ready.
//   Write it only while no scan is in flight.
// Flow: a scan accepted at one edge is registered in the scan register, the report is
// built and compared from that register, and the word is loaded into the output
// register. One scan is taken every cycle while scan.ready is high; the
// single output register lets one new scan enter while a report waits.
// When report.ready is low with a word pending and the scan register is full, it
// holds and scan.ready drops until the word is taken.
// Reset clears the stored last report to zeros, the keycode table to its
// default codes, and empties both registers.
`include "key_matrix_to_boot_report_top_defines.svh"

module key_matrix_to_boot_report_top (
	input  logic          clk,
	input  logic          arst_n,
	kmbr_scan_if.sink     scan,
	kmbr_report_if.source report,
	kmbr_cfg_if.sink      cfg
);
	import kmbr_pkg::*;

	key_table_t key_table_q;
	logic       valid_s1;
	key_bits_t  key_bits_s1;
	logic       host_ready_s1;
	report_t    last_q;
	report_t    out_slots_q;
	logic       out_valid_q;
	report_t    report_d;
	logic [FILL_W-1:0] filled;
	logic       advance;
	logic       load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_table_q <= TABLE_RESET;
		end else if (cfg.valid) begin
			key_table_q <= cfg.data;
		end
	end

	// The output register is free, or is being emptied this cycle.
	assign advance   = !out_valid_q || report.ready;
	assign scan.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			key_bits_s1   <= scan.key_bits;
			host_ready_s1 <= scan.host_ready;
		end
	end

	// Compact the pressed keys into the slots in increasing key order.
	always_comb begin
		report_d = '0;
		filled   = '0;
		for (int k = 0; k < KEY_BITS_W; k++) begin
			if (k < KEY_COUNT && key_bits_s1[k] && filled < FILL_W'(REPORT_SLOTS)) begin
				if (k < TABLE_KEYS) begin
					report_d[filled] = key_table_q[CODE_W*k +: CODE_W];
				end
				filled = filled + FILL_W'(1);
			end
		end
	end

	assign load = valid_s1 && host_ready_s1 && advance && (report_d != last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				last_q      <= report_d;
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_slots_q <= report_d;
		end
	end

	assign report.valid  = out_valid_q;
	assign report.slot_0 = out_slots_q[0];
	assign report.slot_1 = out_slots_q[1];
	assign report.slot_2 = out_slots_q[2];
	assign report.slot_3 = out_slots_q[3];
	assign report.slot_4 = out_slots_q[4];
	assign report.slot_5 = out_slots_q[5];

	`KMBR_ASSERT_IMP(a_pending_matches_last, out_valid_q, out_slots_q == last_q)
	`KMBR_ASSERT_IMP(a_ready_when_out_free, !out_valid_q, scan.ready)
	`KMBR_ASSERT_NXT(a_not_ready_keeps_last, valid_s1 && !host_ready_s1, $stable(last_q))

endmodule

// ===== bench/key_matrix_to_boot_report_top_tb.sv =====
`timescale 1ns / 100ps

module key_matrix_to_boot_report_top_tb;
	import kmbr_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 4;

	logic clk;
	logic arst_n;

	kmbr_scan_if   scan_ch ();
	kmbr_report_if rep_ch ();
	kmbr_cfg_if    cfg_ch ();

	key_matrix_to_boot_report_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_ch),
		.report (rep_ch),
		.cfg    (cfg_ch)
	);

	key_table_t code_table;
	report_t    last_sent;
	report_t    pending_reports[$];
	key_bits_t  prev_bits;
	bit         steady;
	int         errors;
	int         scans_sent;
	int         reports_seen;
	int         table_writes;
	int         cycles;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Compacts the pressed keys, lowest index first, into the report slots.
	function automatic report_t build_report(key_bits_t kb, key_table_t tbl);
		report_t r;
		int      filled;
		r = '0;
		filled = 0;
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (kb[k] && filled < REPORT_SLOTS) begin
				r[filled] = (k < TABLE_KEYS) ? tbl[8*k +: 8] : '0;
				filled++;
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady)
			return 0;
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic key_table_t random_table();
		key_table_t t;
		for (int b = 0; b < TABLE_KEYS; b++)
			t[8*b +: 8] = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
		return t;
	endfunction

	// Checks each report word first, then predicts from the scan taken at the same edge.
	always @(posedge clk) begin
		report_t want;
		report_t got;
		if (arst_n) begin
			if (rep_ch.valid && rep_ch.ready) begin
				got = {rep_ch.slot_5, rep_ch.slot_4, rep_ch.slot_3,
					rep_ch.slot_2, rep_ch.slot_1, rep_ch.slot_0};
				reports_seen++;
				if (pending_reports.size() == 0) begin
					errors++;
					$display("%0t: report word %h arrived with none expected", $time, got);
				end else begin
					want = pending_reports.pop_front();
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (got[i] !== want[i]) begin
							errors++;
							$display("%0t: slot_%0d expected %h, actual %h",
								$time, i, want[i], got[i]);
						end
					end
				end
			end
			if (scan_ch.valid && scan_ch.ready && scan_ch.host_ready) begin
				want = build_report(scan_ch.key_bits, code_table);
				if (want != last_sent) begin
					pending_reports.push_back(want);
					last_sent = want;
				end
			end
			if (cfg_ch.valid && cfg_ch.ready)
				code_table = cfg_ch.data;
		end
	end

	// The report sink alternates runs of readiness with stalls of random length.
	initial begin
		int n;
		rep_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = steady ? 1 : $urandom_range(1, 8);
			repeat (n) begin
				@(negedge clk);
				rep_ch.ready <= 1'b1;
			end
			n = pick_gap();
			repeat (n) begin
				@(negedge clk);
				rep_ch.ready <= 1'b0;
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: cycle limit reached", $time);
		$display("key_matrix_to_boot_report_top_tb: done, errors");
		$finish;
	end

	task automatic send_scan(input key_bits_t kb, input logic hr);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			scan_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		scan_ch.valid      <= 1'b1;
		scan_ch.key_bits   <= kb;
		scan_ch.host_ready <= hr;
		do @(posedge clk); while (!scan_ch.ready);
		scans_sent++;
	endtask

	// Stops sending and waits until every expected word has come and the pipeline is empty.
	task automatic drain_reports();
		@(negedge clk);
		scan_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_table(input key_table_t value);
		drain_reports();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		table_writes++;
	endtask

	task automatic run_random(input int count);
		key_bits_t bits;
		logic      hr;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 50)
				steady = 1'b1;
			if (i % 100 == 80)
				steady = 1'b0;
			bits = ($urandom_range(0, 3) == 0) ? prev_bits : key_bits_t'($urandom_range(0, 15));
			hr = ($urandom_range(0, 7) != 0);
			send_scan(bits, hr);
			prev_bits = bits;
		end
		steady = 1'b0;
	endtask

	// Every key pattern under the reset table, with repeated scans and scans the host refuses; 4'h5 is sent only refused.
	task automatic test_default_table();
		send_scan(4'h0, 1'b1);
		send_scan(4'h1, 1'b1);
		send_scan(4'h1, 1'b1);
		send_scan(4'h2, 1'b1);
		send_scan(4'h4, 1'b1);
		send_scan(4'h8, 1'b1);
		send_scan(4'hF, 1'b1);
		send_scan(4'hF, 1'b0);
		send_scan(4'h0, 1'b0);
		send_scan(4'h5, 1'b0);
		send_scan(4'hF, 1'b1);
		send_scan(4'h0, 1'b1);
		send_scan(4'hA, 1'b1);
		send_scan(4'h6, 1'b1);
		send_scan(4'h9, 1'b1);
		send_scan(4'h3, 1'b1);
		send_scan(4'hC, 1'b1);
		send_scan(4'h7, 1'b1);
		send_scan(4'hE, 1'b1);
		send_scan(4'hB, 1'b1);
		send_scan(4'hD, 1'b1);
	endtask

	// All-zero and all-ones tables, and one where some pressed keys map to a zero code.
	task automatic test_table_extremes();
		write_table('0);
		send_scan(4'hF, 1'b1);
		run_random(150);
		write_table('1);
		run_random(150);
		write_table(64'hFF00_FF00_00FF_00FF);
		send_scan(4'h1, 1'b1);
		send_scan(4'h3, 1'b1);
		send_scan(4'h5, 1'b1);
		send_scan(4'hF, 1'b1);
		run_random(150);
	endtask

	task automatic test_random_tables();
		repeat (6) begin
			write_table(random_table());
			run_random(125);
			// The sender holds off here until every outstanding word has arrived.
			drain_reports();
			run_random(125);
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		scan_ch.valid      = 1'b0;
		scan_ch.key_bits   = '0;
		scan_ch.host_ready = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.data        = '0;
		code_table         = TABLE_RESET;
		last_sent          = '0;
		prev_bits          = '0;
		steady             = 1'b0;
		errors             = 0;
		scans_sent         = 0;
		reports_seen       = 0;
		table_writes       = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_default_table();
		test_table_extremes();
		test_random_tables();
		drain_reports();

		$display("Covered %0d scans and %0d report words over %0d keycode table settings,",
			scans_sent, reports_seen, table_writes + 1);
		$display("with refused scans, unchanged reports and stalls on both sides; %0d mismatches.",
			errors);
		if (errors == 0)
			$display("key_matrix_to_boot_report_top_tb: done, clean");
		else
			$display("key_matrix_to_boot_report_top_tb: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/kmbr_pkg.sv
design/kmbr_scan_if.sv
design/kmbr_report_if.sv
design/kmbr_cfg_if.sv
design/key_matrix_to_boot_report_top.sv
bench/key_matrix_to_boot_report_top_tb.sv
